// ----- rtl/core/civil_date_to_packed_segment_id_top_macros.svh -----
// Assertion macros for the civil date to packed segment id block.
`ifndef CIVIL_DATE_TO_PACKED_SEGMENT_ID_TOP_MACROS_SVH
`define CIVIL_DATE_TO_PACKED_SEGMENT_ID_TOP_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define CDPSID_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cdpsid same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define CDPSID_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cdpsid next-cycle check failed");

`endif

// ----- rtl/core/cdpsid_pkg.sv -----
// Package: field layout, reciprocal constants, status codes and date tables.
package cdpsid_pkg;

	// Packing widths of the id
	localparam int SEQ_WIDTH = 15;
	localparam int CYC_WIDTH = 16;
	localparam int ID_W      = 63;
	localparam int EM_WIDTH  = ID_W - CYC_WIDTH - SEQ_WIDTH;

	// Input field widths and tdata layout
	localparam int DW_W       = 27;
	localparam int ST_W       = 14;
	localparam int CL_W       = 20;
	localparam int SN_W       = 20;
	localparam int DW_LSB     = 0;
	localparam int ST_LSB     = DW_LSB + DW_W;
	localparam int CL_LSB     = ST_LSB + ST_W;
	localparam int SN_LSB     = CL_LSB + CL_W;
	localparam int IN_BITS    = SN_LSB + SN_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((ID_W + 7) / 8) * 8;
	localparam int STATUS_W   = 3;

	// Bounds
	localparam logic [63:0]     EM_MAX  = (64'd1 << EM_WIDTH) - 64'd1;
	localparam logic [CL_W-1:0] CYC_MAX = CL_W'((64'd1 << CYC_WIDTH) - 64'd1);
	localparam logic [SN_W-1:0] SEQ_MAX = SN_W'((64'd1 << SEQ_WIDTH) - 64'd1);

	// Exact reciprocals: ceil(2^k / d), error term small enough for the input range
	localparam logic [63:0] RECIP_10K_64 = ((64'd1 << 41) + 64'd9999) / 64'd10000;
	localparam logic [27:0] RECIP_10K    = RECIP_10K_64[27:0];
	localparam logic [63:0] RECIP_100_64 = ((64'd1 << 21) + 64'd99) / 64'd100;
	localparam logic [14:0] RECIP_100    = RECIP_100_64[14:0];
	// Shared by /25 (shift 16) and /100 (shift 18) of a 12-bit value
	localparam logic [63:0] RECIP_Q4_64  = ((64'd1 << 16) + 64'd24) / 64'd25;
	localparam logic [11:0] RECIP_Q4     = RECIP_Q4_64[11:0];

	// Day count offsets: one 400-year era (added by the year shift) plus 1970-01-01
	localparam logic [63:0] EPOCH_OFS_64 = 64'd146097 + 64'd719468;
	localparam logic [19:0] EPOCH_OFS    = EPOCH_OFS_64[19:0];
	localparam logic [13:0] YEAR_SHIFT   = 14'd400;
	localparam logic [13:0] MIN_PER_DAY  = 14'd1440;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_BAD_DATE  = 3'd2,
		ST_BAD_TIME  = 3'd3,
		ST_RANGE     = 3'd4,
		ST_BAD_CYCLE = 3'd5,
		ST_BAD_SEQ   = 3'd6
	} status_t;

	// Fields that ride along the pipeline untouched once set
	typedef struct packed {
		logic            empty;
		logic            bad_time;
		logic            bad_date;
		logic [13:0]     tod;
		logic [CL_W-1:0] cyc;
		logic [SN_W-1:0] seq;
	} side_t;

	// Days in a month; month outside 1..12 gives 0
	function automatic logic [4:0] month_len(input logic [6:0] mon, input logic leap);
		logic [4:0] len;
		unique case (mon)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
			7'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days from March 1 to the first of the month, year starting in March
	function automatic logic [8:0] doy_base(input logic [6:0] mon);
		logic [8:0] base;
		unique case (mon)
			7'd3:    base = 9'd0;
			7'd4:    base = 9'd31;
			7'd5:    base = 9'd61;
			7'd6:    base = 9'd92;
			7'd7:    base = 9'd122;
			7'd8:    base = 9'd153;
			7'd9:    base = 9'd184;
			7'd10:   base = 9'd214;
			7'd11:   base = 9'd245;
			7'd12:   base = 9'd275;
			7'd1:    base = 9'd306;
			7'd2:    base = 9'd337;
			default: base = 9'd0;
		endcase
		return base;
	endfunction

endpackage

// ----- rtl/core/civil_date_to_packed_segment_id_top.sv -----
// Top level: civil date and time to packed segment id conversion pipeline.
//
// Usage:
//   Input channel s_axis carries one request per transaction: a decimal yyyymmdd date,
//   a decimal hhmm start time, a cycle length in minutes and a sequence number.
//   Output channel m_axis returns one transaction per request, in order: the 63-bit
//   packed id (epoch minutes, cycle, sequence) in tdata and a status code in tuser.
//   Any failed check gives a nonzero status and an id of zero.
// Timing:
//   Ten register stages; the last is the output register that drives m_axis. One
//   request per cycle is sustained while m_axis_tready stays high; the stage count is
//   set by the constant-reciprocal multipliers, each followed by a register.
// Reset:
//   arst_n clears all stage valid flags at once; data registers are not cleared.
// Backpressure:
//   Each stage loads when it is empty or the stage after it moves, so bubbles
//   collapse. s_axis_tready drops only when every stage holds a request and the
//   result in the output register is not being taken.
`include "civil_date_to_packed_segment_id_top_macros.svh"

module civil_date_to_packed_segment_id_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// date_word[26:0], start_time[40:27], cycle_len[60:41], seq_number[80:61], zeros
	input  logic [cdpsid_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// packed_id[62:0], zero
	output logic [cdpsid_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// status[2:0]
	output logic [cdpsid_pkg::STATUS_W-1:0]     m_axis_tuser
);
	import cdpsid_pkg::*;

	localparam int NSTG = 10;

	// Stage valid flags and per-stage load enables
	logic [NSTG:1] vld_q;
	logic [NSTG:1] adv;

	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign s_axis_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: capture the request
	logic [DW_W-1:0] dw_s1;
	logic [ST_W-1:0] st_s1;
	logic [CL_W-1:0] cyc_s1;
	logic [SN_W-1:0] seq_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dw_s1  <= s_axis_tdata[DW_LSB +: DW_W];
			st_s1  <= s_axis_tdata[ST_LSB +: ST_W];
			cyc_s1 <= s_axis_tdata[CL_LSB +: CL_W];
			seq_s1 <= s_axis_tdata[SN_LSB +: SN_W];
		end
	end

	// Stage 2: year = date / 10000, hour = time / 100 by reciprocal multiply
	logic [54:0]     prod_y;
	logic [28:0]     prod_h;
	logic [13:0]     yq_s2;
	logic [7:0]      hq_s2;
	logic [DW_W-1:0] dw_s2;
	logic [ST_W-1:0] st_s2;
	logic [CL_W-1:0] cyc_s2;
	logic [SN_W-1:0] seq_s2;

	assign prod_y = 55'(dw_s1) * 55'(RECIP_10K);
	assign prod_h = 29'(st_s1) * 29'(RECIP_100);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			yq_s2  <= prod_y[54:41];
			hq_s2  <= prod_h[28:21];
			dw_s2  <= dw_s1;
			st_s2  <= st_s1;
			cyc_s2 <= cyc_s1;
			seq_s2 <= seq_s1;
		end
	end

	// Stage 3: remainders mmdd and minutes
	logic [DW_W-1:0] md_full;
	logic [ST_W-1:0] mm_full;
	logic [13:0]     year_s3;
	logic [13:0]     md_s3;
	logic [7:0]      hh_s3;
	logic [6:0]      mm_s3;
	side_t           side_s3;

	assign md_full = dw_s2 - DW_W'(yq_s2) * DW_W'(10000);
	assign mm_full = st_s2 - ST_W'(hq_s2) * ST_W'(100);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			year_s3          <= yq_s2;
			md_s3            <= md_full[13:0];
			hh_s3            <= hq_s2;
			mm_s3            <= mm_full[6:0];
			side_s3.empty    <= (dw_s2 == '0);
			side_s3.bad_time <= 1'b0;
			side_s3.bad_date <= 1'b0;
			side_s3.tod      <= '0;
			side_s3.cyc      <= cyc_s2;
			side_s3.seq      <= seq_s2;
		end
	end

	// Stage 4: month = mmdd / 100, century = year / 100, time of day check
	logic [28:0] prod_m;
	logic [28:0] prod_c;
	logic [6:0]  mon_s4;
	logic [7:0]  yc_s4;
	logic [13:0] year_s4;
	logic [13:0] md_s4;
	side_t       side_c4;
	side_t       side_s4;

	assign prod_m = 29'(md_s3) * 29'(RECIP_100);
	assign prod_c = 29'(year_s3) * 29'(RECIP_100);

	always_comb begin
		side_c4          = side_s3;
		side_c4.bad_time = (hh_s3 > 8'd23) || (mm_s3 > 7'd59);
		side_c4.tod      = 14'(hh_s3) * 14'd60 + 14'(mm_s3);
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			mon_s4  <= prod_m[27:21];
			yc_s4   <= prod_c[28:21];
			year_s4 <= year_s3;
			md_s4   <= md_s3;
			side_s4 <= side_c4;
		end
	end

	// Stage 5: day of month and leap year flag
	logic [13:0] day_full;
	logic [6:0]  day_s5;
	logic [6:0]  mon_s5;
	logic [13:0] year_s5;
	logic        leap_s5;
	side_t       side_s5;

	assign day_full = md_s4 - 14'(mon_s4) * 14'd100;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			day_s5  <= day_full[6:0];
			mon_s5  <= mon_s4;
			year_s5 <= year_s4;
			leap_s5 <= (year_s4[1:0] == 2'd0) &&
			           ((year_s4 != 14'(yc_s4) * 14'd100) || (yc_s4[1:0] == 2'd0));
			side_s5 <= side_s4;
		end
	end

	// Stage 6: date check, March-based year and day of year
	logic  [13:0] ys_s6;
	logic  [8:0]  doy_s6;
	side_t        side_c6;
	side_t        side_s6;

	always_comb begin
		side_c6          = side_s5;
		side_c6.bad_date = (mon_s5 == 7'd0) || (mon_s5 > 7'd12) || (day_s5 == 7'd0) ||
		                   (day_s5 > 7'(month_len(mon_s5, leap_s5)));
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			ys_s6   <= year_s5 + YEAR_SHIFT - 14'(mon_s5 <= 7'd2);
			doy_s6  <= doy_base(mon_s5) + 9'(day_s5) - 9'd1;
			side_s6 <= side_c6;
		end
	end

	// Stage 7: year days and the quarter-year product shared by /100 and /400
	logic [11:0] q4_s7;
	logic [22:0] base_s7;
	logic [23:0] p_s7;
	side_t       side_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			q4_s7   <= ys_s6[13:2];
			base_s7 <= 23'(ys_s6) * 23'd365 + 23'(doy_s6);
			p_s7    <= 24'(ys_s6[13:2]) * 24'(RECIP_Q4);
			side_s7 <= side_s6;
		end
	end

	// Stage 8: days since 1970-01-01, may be negative
	logic [24:0] days_full;
	logic [23:0] days_s8;
	side_t       side_s8;

	assign days_full = 25'(base_s7) + 25'(q4_s7) - 25'(p_s7[23:16]) + 25'(p_s7[23:18])
	                 - 25'(EPOCH_OFS);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			days_s8 <= days_full[23:0];
			side_s8 <= side_s7;
		end
	end

	// Stage 9: epoch minutes, two's complement
	localparam int EMC_W = 35;
	logic [EMC_W-1:0] em_s9;
	side_t            side_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			em_s9   <= {{(EMC_W-24){days_s8[23]}}, days_s8} * EMC_W'(MIN_PER_DAY)
			         + EMC_W'(side_s8.tod);
			side_s9 <= side_s8;
		end
	end

	// Stage 10: status priority and id packing into the output register
	logic [63:0]   em_ext;
	logic          em_bad;
	logic [63:0]   id_full;
	status_t       status_c;
	status_t       status_q;
	logic [ID_W-1:0] id_q;

	assign em_ext  = 64'(em_s9);
	assign em_bad  = em_s9[EMC_W-1] || (em_ext > EM_MAX);
	assign id_full = (em_ext << (CYC_WIDTH + SEQ_WIDTH)) | (64'(side_s9.cyc) << SEQ_WIDTH)
	               | 64'(side_s9.seq);

	always_comb begin
		if (side_s9.empty) begin
			status_c = ST_EMPTY;
		end else if (side_s9.bad_date) begin
			status_c = ST_BAD_DATE;
		end else if (side_s9.bad_time) begin
			status_c = ST_BAD_TIME;
		end else if (em_bad) begin
			status_c = ST_RANGE;
		end else if ((side_s9.cyc == '0) || (side_s9.cyc > CYC_MAX)) begin
			status_c = ST_BAD_CYCLE;
		end else if (side_s9.seq > SEQ_MAX) begin
			status_c = ST_BAD_SEQ;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			status_q <= status_c;
			id_q     <= (status_c == ST_OK) ? id_full[ID_W-1:0] : '0;
		end
	end

	assign m_axis_tvalid = vld_q[NSTG];
	assign m_axis_tdata  = OUT_TDATA_W'(id_q);
	assign m_axis_tuser  = status_q;

	// Output transaction classes seen by the checks below
	logic out_err;
	logic out_ok;

	assign out_err = m_axis_tvalid && (m_axis_tuser != ST_OK);
	assign out_ok  = m_axis_tvalid && (m_axis_tuser == ST_OK);

	// Input is held off only behind a stalled, full pipeline
	`CDPSID_ASSERT_IMP(a_ready_only_stalls, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
	// A failed request never carries an id
	`CDPSID_ASSERT_IMP(a_err_zero_id, out_err, m_axis_tdata == '0)
	// An accepted id always holds a nonzero cycle field
	`CDPSID_ASSERT_IMP(a_ok_has_cycle, out_ok, m_axis_tdata[SEQ_WIDTH +: CYC_WIDTH] != '0)

endmodule

// ----- bench/civil_date_to_packed_segment_id_top_tb.sv -----
// Self-checking bench for the civil date to packed segment id pipeline.
module civil_date_to_packed_segment_id_top_tb;
	import cdpsid_pkg::*;

	localparam int NUM_PROBES = 28;
	localparam int NUM_RANDOM = 1122;
	localparam int LONG_HOLD  = 120;
	localparam int DRAIN_WAIT = 20000;
	localparam int TAIL_WAIT  = 20;

	typedef struct {
		logic [62:0] id;
		status_t     status;
	} seg_result_t;

	// One row of the directed table; typed rows carry their own answer
	typedef struct {
		logic [DW_W-1:0] date;
		logic [ST_W-1:0] tod;
		logic [CL_W-1:0] cyc;
		logic [SN_W-1:0] seq;
		bit              typed;
		logic [62:0]     id;
		status_t         status;
	} probe_row_t;

	typedef enum int {
		SHAPE_CLEAN,
		SHAPE_BROKEN,
		SHAPE_NOISE
	} req_shape_e;

	typedef enum int {
		FLAW_MONTH,
		FLAW_DAY,
		FLAW_HOUR,
		FLAW_MINUTE,
		FLAW_CYCLE,
		FLAW_SEQ,
		FLAW_EARLY
	} flaw_e;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_CYCLIC
	} ready_mode_e;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// date_word, start_time, cycle_len, seq_number from bit 0 up, zero padded
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// packed_id, zero pad bit
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// status
	logic [STATUS_W-1:0]    m_axis_tuser;

	seg_result_t pending_ids[$];
	int unsigned results_checked = 0;
	int unsigned failures        = 0;
	int          burst_left      = 0;

	probe_row_t probe_rows [NUM_PROBES] = '{
		// empty date, also when every other field is bad
		'{27'd0,        14'd0,    20'd1,       20'd0,       1'b1, 63'h0,        ST_EMPTY},
		'{27'd0,        14'd2400, 20'd0,       20'd1048575, 1'b1, 63'h0,        ST_EMPTY},
		// first minute of the epoch, then one minute later, then widest cycle and sequence
		'{27'd19700101, 14'd0,    20'd1,       20'd0,       1'b1, 63'h8000,     ST_OK},
		'{27'd19700101, 14'd1,    20'd1,       20'd0,       1'b1, 63'h80008000, ST_OK},
		'{27'd19700101, 14'd0,    20'd65535,   20'd32767,   1'b1, 63'h7fffffff, ST_OK},
		// last minute before the epoch; year zero is leap but still too early
		'{27'd19691231, 14'd2359, 20'd1,       20'd0,       1'b1, 63'h0,        ST_RANGE},
		'{27'd229,      14'd0,    20'd1,       20'd0,       1'b1, 63'h0,        ST_RANGE},
		'{27'd230,      14'd0,    20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_DATE},
		// month and day out of range
		'{27'd20231301, 14'd1200, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_DATE},
		'{27'd20230015, 14'd1200, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_DATE},
		'{27'd20230100, 14'd1200, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_DATE},
		'{27'd20230199, 14'd1200, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_DATE},
		// leap rules: common year, century year, four-century year, plain leap year
		'{27'd20230229, 14'd1200, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_DATE},
		'{27'd19000229, 14'd1200, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_DATE},
		'{27'd20000229, 14'd1234, 20'd60,      20'd7,       1'b0, 63'h0,        ST_OK},
		'{27'd20240229, 14'd0,    20'd15,      20'd100,     1'b0, 63'h0,        ST_OK},
		// bad date wins over bad time
		'{27'd20230431, 14'd2460, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_DATE},
		'{27'd99999999, 14'd9999, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_DATE},
		// latest minute the date word can name
		'{27'd99991231, 14'd2359, 20'd65535,   20'd32767,   1'b0, 63'h0,        ST_OK},
		'{27'd20230615, 14'd2400, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_TIME},
		'{27'd20230615, 14'd60,   20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_TIME},
		'{27'd20230615, 14'd9999, 20'd1,       20'd0,       1'b1, 63'h0,        ST_BAD_TIME},
		'{27'd20230615, 14'd1330, 20'd0,       20'd0,       1'b1, 63'h0,        ST_BAD_CYCLE},
		'{27'd20230615, 14'd1330, 20'd65536,   20'd0,       1'b1, 63'h0,        ST_BAD_CYCLE},
		'{27'd20230615, 14'd1330, 20'd1048575, 20'd1048575, 1'b1, 63'h0,        ST_BAD_CYCLE},
		'{27'd20230615, 14'd1330, 20'd1,       20'd32768,   1'b1, 63'h0,        ST_BAD_SEQ},
		'{27'd20230615, 14'd1330, 20'd1,       20'd1048575, 1'b1, 63'h0,        ST_BAD_SEQ},
		// epoch range is checked before the cycle and the sequence
		'{27'd19691231, 14'd2359, 20'd0,       20'd1048575, 1'b1, 63'h0,        ST_RANGE}
	};

	civil_date_to_packed_segment_id_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_leap(input longint yr);
		return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
	endfunction

	// Month must already be in 1..12
	function automatic longint days_in_month(input longint yr, input longint mon);
		case (mon)
			2:            return is_leap(yr) ? 29 : 28;
			4, 6, 9, 11:  return 30;
			default:      return 31;
		endcase
	endfunction

	// Civil day count: years start in March, 400-year eras of 146097 days
	function automatic longint days_since_epoch(input longint yr, input longint mon,
			input longint dd);
		longint shifted, era, yoe, mar_mon, doy, doe;
		shifted = yr - ((mon <= 2) ? 1 : 0) + 400;
		era     = shifted / 400 - 1;
		yoe     = shifted % 400;
		mar_mon = (mon > 2) ? mon - 3 : mon + 9;
		doy     = (153 * mar_mon + 2) / 5 + dd - 1;
		doe     = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	function automatic seg_result_t segment_id_of(input logic [DW_W-1:0] dw,
			input logic [ST_W-1:0] st, input logic [CL_W-1:0] cyc,
			input logic [SN_W-1:0] seq);
		seg_result_t res;
		longint yr, mon, dd, hh, mn, em;
		res.id     = '0;
		res.status = ST_OK;
		yr  = longint'(dw) / 10000;
		mon = (longint'(dw) / 100) % 100;
		dd  = longint'(dw) % 100;
		hh  = longint'(st) / 100;
		mn  = longint'(st) % 100;
		if (dw == '0) begin
			res.status = ST_EMPTY;
		end else if (mon < 1 || mon > 12 || dd < 1 || dd > days_in_month(yr, mon)) begin
			res.status = ST_BAD_DATE;
		end else if (hh > 23 || mn > 59) begin
			res.status = ST_BAD_TIME;
		end else begin
			em = days_since_epoch(yr, mon, dd) * 1440 + hh * 60 + mn;
			if (em < 0 || em > longint'(EM_MAX)) begin
				res.status = ST_RANGE;
			end else if (cyc == '0 || cyc > CYC_MAX) begin
				res.status = ST_BAD_CYCLE;
			end else if (seq > SEQ_MAX) begin
				res.status = ST_BAD_SEQ;
			end else begin
				res.id = 63'((64'(em) << (CYC_WIDTH + SEQ_WIDTH))
					| (64'(cyc) << SEQ_WIDTH) | 64'(seq));
			end
		end
		return res;
	endfunction

	// Mostly real dates with legal fields, some with one field spoiled, the rest noise
	task automatic make_random_request(output logic [DW_W-1:0] dw,
			output logic [ST_W-1:0] st, output logic [CL_W-1:0] cyc,
			output logic [SN_W-1:0] seq);
		req_shape_e shape;
		flaw_e      flaw;
		int         roll, yr, mon, dd, len, hh, mn;
		roll  = $urandom_range(0, 99);
		shape = (roll < 75) ? SHAPE_CLEAN : (roll < 88) ? SHAPE_BROKEN : SHAPE_NOISE;
		if (shape == SHAPE_NOISE) begin
			dw  = ($urandom_range(0, 15) == 0) ? '0 : DW_W'($urandom_range(0, 99999999));
			st  = ST_W'($urandom_range(0, 9999));
			cyc = CL_W'($urandom);
			seq = SN_W'($urandom);
		end else begin
			yr  = ($urandom_range(0, 7) == 0) ? $urandom_range(1970, 2100)
				: $urandom_range(1970, 9999);
			mon = $urandom_range(1, 12);
			len = int'(days_in_month(yr, mon));
			dd  = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
			hh  = ($urandom_range(0, 7) == 0) ? 23 : $urandom_range(0, 23);
			mn  = ($urandom_range(0, 7) == 0) ? 59 : $urandom_range(0, 59);
			case ($urandom_range(0, 3))
				0:       cyc = CL_W'(1);
				1:       cyc = CYC_MAX;
				default: cyc = CL_W'($urandom_range(1, 65535));
			endcase
			case ($urandom_range(0, 3))
				0:       seq = '0;
				1:       seq = SEQ_MAX;
				default: seq = SN_W'($urandom_range(0, 32767));
			endcase
			if (shape == SHAPE_BROKEN) begin
				flaw = flaw_e'($urandom_range(0, 6));
				case (flaw)
					FLAW_MONTH:  mon = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
					FLAW_DAY:    dd  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(len + 1, 99);
					FLAW_HOUR:   hh  = $urandom_range(24, 99);
					FLAW_MINUTE: mn  = $urandom_range(60, 99);
					FLAW_CYCLE:  cyc = ($urandom_range(0, 1) == 0) ? '0
						: CL_W'($urandom_range(65536, 1048575));
					FLAW_SEQ:    seq = SN_W'($urandom_range(32768, 1048575));
					FLAW_EARLY: begin
						yr  = $urandom_range(0, 1969);
						len = int'(days_in_month(yr, mon));
						dd  = $urandom_range(1, len);
					end
				endcase
			end
			dw = DW_W'(yr * 10000 + mon * 100 + dd);
			st = ST_W'(hh * 100 + mn);
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_request(input logic [DW_W-1:0] dw, input logic [ST_W-1:0] st,
			input logic [CL_W-1:0] cyc, input logic [SN_W-1:0] seq,
			input bit typed, input seg_result_t typed_res);
		seg_result_t due;
		s_axis_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, seq, cyc, st, dw};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		due = typed ? typed_res : segment_id_of(dw, st, cyc, seq);
		pending_ids.insert(pending_ids.size(), due);
		@(negedge clk);
	endtask

	// Count down the current burst; at its end drop valid for a random gap
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 12);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Hold the sender until every transaction in flight has come back
	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		while (pending_ids.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [DW_W-1:0] dw;
		logic [ST_W-1:0] st;
		logic [CL_W-1:0] cyc;
		logic [SN_W-1:0] seq;
		seg_result_t     typed_res;
		int              i;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		for (i = 0; i < NUM_PROBES; i++) begin
			typed_res.id     = probe_rows[i].id;
			typed_res.status = probe_rows[i].status;
			offer_request(probe_rows[i].date, probe_rows[i].tod, probe_rows[i].cyc,
				probe_rows[i].seq, probe_rows[i].typed, typed_res);
			pace_sender();
		end
		drain_outputs();

		// Random part; pause once midway until the pipeline runs empty
		for (i = 0; i < NUM_RANDOM; i++) begin
			make_random_request(dw, st, cyc, seq);
			offer_request(dw, st, cyc, seq, 1'b0, typed_res);
			if (i == NUM_RANDOM / 2)
				drain_outputs();
			else
				pace_sender();
		end
		s_axis_tvalid <= 1'b0;

		for (i = 0; i < DRAIN_WAIT && pending_ids.size() != 0; i++) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (pending_ids.size() != 0) begin
			$error("%0d expected results never arrived", pending_ids.size());
			failures++;
		end
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: switch among stall patterns; once, hold off long enough to back up the input
	initial begin : receiver
		ready_mode_e mode;
		int          span, phase, k;
		bit          held;
		mode  = READY_ALWAYS;
		span  = 0;
		phase = 0;
		held  = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_checked >= 400) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				for (k = 0; k < LONG_HOLD; k++) @(negedge clk);
			end
			if (span == 0) begin
				mode = ready_mode_e'($urandom_range(0, 3));
				span = $urandom_range(10, 200);
			end
			span--;
			phase++;
			case (mode)
				READY_ALWAYS: m_axis_tready <= 1'b1;
				READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				READY_CYCLIC: m_axis_tready <= (phase % 5 != 0);
			endcase
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		seg_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_ids.size() == 0) begin
				$error("result with no expectation: packed_id %h status %0d",
					m_axis_tdata, m_axis_tuser);
				failures++;
			end else begin
				want = pending_ids.pop_front();
				if (m_axis_tdata !== {1'b0, want.id}) begin
					$error("packed_id: expected %h, actual %h", {1'b0, want.id}, m_axis_tdata);
					failures++;
				end
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
					failures++;
				end
			end
			results_checked++;
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
